>>> rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    // Ring geometry and field widths.
    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;
    localparam int SUM_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic CFG_IDX_CAPACITY = 1'b0;
    localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(1024);

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_BACK  = 2'd3;

    // Value reported for front and rear when the queue is empty.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     empty_res;
        logic                     full_res;
        logic [CNT_W-1:0]         count;
    } out_item_t;

    // Ring position pos + off, where off stays below DEPTH.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bounded_double_ended_queue_core.sv
// Bounded double-ended queue of 32-bit signed values held in a 1024-entry ring.
// Input channel (s_valid, s_ready, s_data): each transfer carries an operation
// code and a value: insert front, insert back, delete front or delete back.
// Result channel (m_valid, m_ready, m_data): exactly one result per operation,
// giving success, the front and rear values (-1 when empty), the empty and
// full flags and the entry count, in the order the operations were taken.
// The APB port holds the capacity register at address 0 (reset value 1024);
// write it only while the queue is empty and no operation is in flight.
// An accepted operation updates the pointers and issues the one write or read of
// the entry memory in its accept cycle; the block then enters its busy state,
// takes the registered read data and loads the output register once that
// register is free. A new operation is not accepted until the result of the
// previous one has been loaded into the output register.
// If the receiver stalls, the finished result waits in the output register
// while the next operation is already taken; that one then waits for the
// output register to empty, and the input stays stalled until it does.
// Reset clears the head pointer, the count and the handshakes; the memory
// needs no clearing pass since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue_core import bdq_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [CNT_W-1:0] capacity;

    // Configuration register block.
    bdq_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // Queue control with its entry memory.
    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (capacity),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/bdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bdq_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_cfg import bdq_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [CNT_W-1:0]  capacity
);

    logic [CNT_W-1:0] capacity_reg;
    logic [CNT_W-1:0] capacity_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Capacity register, written in the access phase of a transfer.
    always_comb begin
        capacity_next = capacity_reg;
        if (wr_en && (paddr[2] == CFG_IDX_CAPACITY)) begin
            capacity_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Read back; addresses beyond the register read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_CAPACITY) begin
            prdata = APB_DW'(capacity_reg);
        end
    end

    assign capacity = capacity_reg;

endmodule

`default_nettype wire

>>> rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CNT_W-1:0] capacity,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic                     state_reg, state_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] rear_reg, rear_next;
    logic                     ok_reg, ok_next;
    logic                     pend_front_reg, pend_front_next;
    logic                     pend_rear_reg, pend_rear_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;

    logic [CNT_W-1:0]  cap_eff;
    logic              accept;
    logic              can_ins;
    logic              can_del;
    logic              emit;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic signed [DATA_W-1:0] front_cur;
    logic signed [DATA_W-1:0] rear_cur;

    // Entry store.
    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capacity above the ring depth saturates at the depth.
    assign cap_eff  = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign can_ins  = (count_reg < cap_eff);
    assign can_del  = (count_reg != '0);
    assign emit     = (state_reg == ST_BUSY) && (!m_valid_reg || m_ready);
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : (head_reg - IDX_W'(1));
    assign head_inc = ring_add(head_reg, CNT_W'(1));

    // The new end of the queue comes from memory after a delete, else from the cache.
    assign front_cur = pend_front_reg ? $signed(ram_rdata) : front_reg;
    assign rear_cur  = pend_rear_reg  ? $signed(ram_rdata) : rear_reg;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        ok_next         = ok_reg;
        pend_front_next = pend_front_reg;
        pend_rear_next  = pend_rear_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        // A waiting result leaves on its transfer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Accept cycle: update pointers and issue the memory access.
        if (accept) begin
            state_next      = ST_BUSY;
            ok_next         = 1'b0;
            pend_front_next = 1'b0;
            pend_rear_next  = 1'b0;
            unique case (s_data.kind)
                KIND_INS_FRONT: begin
                    if (can_ins) begin
                        ok_next    = 1'b1;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = head_dec;
                        front_next = s_data.value;
                        if (count_reg == '0) begin
                            rear_next = s_data.value;
                        end
                    end
                end
                KIND_INS_BACK: begin
                    if (can_ins) begin
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        ram_we     = 1'b1;
                        ram_waddr  = ring_add(head_reg, count_reg);
                        rear_next  = s_data.value;
                        if (count_reg == '0) begin
                            front_next = s_data.value;
                        end
                    end
                end
                KIND_DEL_FRONT: begin
                    if (can_del) begin
                        ok_next    = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg > CNT_W'(1)) begin
                            ram_re          = 1'b1;
                            ram_raddr       = head_inc;
                            pend_front_next = 1'b1;
                        end
                    end
                end
                KIND_DEL_BACK: begin
                    if (can_del) begin
                        ok_next    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg > CNT_W'(1)) begin
                            ram_re         = 1'b1;
                            ram_raddr      = ring_add(head_reg, count_reg - CNT_W'(2));
                            pend_rear_next = 1'b1;
                        end
                    end
                end
                default: begin
                    ok_next = 1'b0;
                end
            endcase
        end

        // Busy state: read data is in; form the result once the output is free.
        if (emit) begin
            state_next                = ST_IDLE;
            front_next                = front_cur;
            rear_next                 = rear_cur;
            pend_front_next           = 1'b0;
            pend_rear_next            = 1'b0;
            m_valid_next              = 1'b1;
            m_data_next.ok            = ok_reg;
            m_data_next.front_value   = (count_reg == '0) ? EMPTY_VALUE : front_cur;
            m_data_next.rear_value    = (count_reg == '0) ? EMPTY_VALUE : rear_cur;
            m_data_next.empty_res     = (count_reg == '0);
            m_data_next.full_res      = (count_reg >= cap_eff);
            m_data_next.count         = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            pend_rear_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            pend_rear_reg  <= pend_rear_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg  <= front_next;
        rear_reg   <= rear_next;
        ok_reg     <= ok_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("entry count exceeds ring depth");

    // An accepted item is always followed by its result cycle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_BUSY))
        else $error("accepted item did not enter its result cycle");

    // A successful insert adds exactly one entry.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.kind[1] && can_ins) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not add one entry");

    // A memory read is only pending while the result is being formed.
    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_front_reg || pend_rear_reg) |-> (state_reg == ST_BUSY))
        else $error("read pending outside the result cycle");

endmodule

`default_nettype wire

>>> tb/tb_bounded_double_ended_queue_core.sv
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue_core;
    import bdq_pkg::*;

    localparam logic [APB_AW-1:0] CAPACITY_ADDR = APB_AW'(4 * CFG_IDX_CAPACITY);
    localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh80000000;
    localparam logic [CNT_W-1:0] CAPACITY_TOP = '1;
    localparam int EXP_SLOTS = 64;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Mirror of the deque: ring contents, head position, fill level and capacity.
    logic signed [DATA_W-1:0] ring_mirror [DEPTH];
    int unsigned              mirror_head;
    int unsigned              mirror_count;
    logic [CNT_W-1:0]         mirror_capacity;

    // Predicted results in a circular buffer, with write and read counts.
    out_item_t expected_results [EXP_SLOTS];
    int        exp_wr_cnt;
    int        exp_rd_cnt;
    int        fail_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;

    bounded_double_ended_queue_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one operation to the mirror and return the result it should give.
    function automatic out_item_t apply_operation(input in_item_t op);
        out_item_t   res;
        int unsigned limit;
        limit  = (mirror_capacity > DEPTH) ? DEPTH : mirror_capacity;
        res.ok = 1'b0;
        case (op.kind)
            KIND_INS_FRONT: begin
                if (mirror_count < limit) begin
                    mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
                    ring_mirror[mirror_head] = op.value;
                    mirror_count++;
                    res.ok = 1'b1;
                end
            end
            KIND_INS_BACK: begin
                if (mirror_count < limit) begin
                    ring_mirror[(mirror_head + mirror_count) % DEPTH] = op.value;
                    mirror_count++;
                    res.ok = 1'b1;
                end
            end
            KIND_DEL_FRONT: begin
                if (mirror_count > 0) begin
                    mirror_head = (mirror_head + 1) % DEPTH;
                    mirror_count--;
                    res.ok = 1'b1;
                end
            end
            KIND_DEL_BACK: begin
                if (mirror_count > 0) begin
                    mirror_count--;
                    res.ok = 1'b1;
                end
            end
        endcase
        if (mirror_count > 0) begin
            res.front_value = ring_mirror[mirror_head];
            res.rear_value  = ring_mirror[(mirror_head + mirror_count - 1) % DEPTH];
        end else begin
            res.front_value = EMPTY_VALUE;
            res.rear_value  = EMPTY_VALUE;
        end
        res.empty_res = (mirror_count == 0);
        res.full_res  = (mirror_count >= limit);
        res.count     = CNT_W'(mirror_count);
        return res;
    endfunction

    // Mostly uniform values, with the extremes mixed in now and then.
    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return MAX_VALUE;
            1: return MIN_VALUE;
            2: return '0;
            3: return -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest outstanding prediction.
    always @(posedge aclk) begin : result_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr_cnt == exp_rd_cnt) begin
                $error("result transfer with no operation outstanding");
                fail_count++;
            end else begin
                want = expected_results[exp_rd_cnt % EXP_SLOTS];
                exp_rd_cnt++;
                if (m_data.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_data.ok);
                    fail_count++;
                end
                if (m_data.front_value !== want.front_value) begin
                    $error("front_value: expected %0d, got %0d",
                           want.front_value, m_data.front_value);
                    fail_count++;
                end
                if (m_data.rear_value !== want.rear_value) begin
                    $error("rear_value: expected %0d, got %0d",
                           want.rear_value, m_data.rear_value);
                    fail_count++;
                end
                if (m_data.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0d, got %0d",
                           want.empty_res, m_data.empty_res);
                    fail_count++;
                end
                if (m_data.full_res !== want.full_res) begin
                    $error("full_res: expected %0d, got %0d",
                           want.full_res, m_data.full_res);
                    fail_count++;
                end
                if (m_data.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, m_data.count);
                    fail_count++;
                end
            end
        end
    end

    // Offer one operation, after an optional idle gap, and wait for its transfer.
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [DATA_W-1:0] value);
        in_item_t item;
        item.kind  = kind;
        item.value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_data  <= in_item_t'($urandom);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results[exp_wr_cnt % EXP_SLOTS] = apply_operation(item);
        exp_wr_cnt++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Read the capacity register back and compare it with the mirror.
    task automatic check_capacity_readback();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAPACITY_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DW'(mirror_capacity)) begin
            $error("capacity readback: expected %0d, got %0d", mirror_capacity, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the capacity once the block is idle; upper data bits are noise.
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        wait_idle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= {(APB_DW - CNT_W)'($urandom), cap};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        mirror_capacity = cap;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_capacity_readback();
    endtask

    // Random operations in runs that lean towards filling, towards draining, or neither.
    task automatic random_operations(input int n_items);
        int run_left;
        int insert_pct;
        run_left   = 0;
        insert_pct = 50;
        repeat (n_items) begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 25);
                case ($urandom_range(2))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            run_left--;
            if ($urandom_range(99) < insert_pct) begin
                send_op($urandom_range(1) ? KIND_INS_FRONT : KIND_INS_BACK, random_value());
            end else begin
                send_op($urandom_range(1) ? KIND_DEL_FRONT : KIND_DEL_BACK, random_value());
            end
        end
    endtask

    // Deletes on an empty queue, inserts of the extreme values, drain to empty.
    task automatic test_empty_and_extremes();
        send_op(KIND_DEL_FRONT, MAX_VALUE);
        send_op(KIND_DEL_BACK, MIN_VALUE);
        send_op(KIND_INS_FRONT, MAX_VALUE);
        send_op(KIND_INS_BACK, MIN_VALUE);
        send_op(KIND_INS_FRONT, '0);
        send_op(KIND_INS_BACK, -32'sd1);
        send_op(KIND_DEL_FRONT, '0);
        send_op(KIND_DEL_BACK, '0);
        send_op(KIND_DEL_BACK, -32'sd1);
        send_op(KIND_DEL_FRONT, '0);
    endtask

    // Zero capacity refuses every insert and reports both empty and full.
    task automatic test_zero_capacity();
        write_capacity('0);
        send_op(KIND_INS_FRONT, 32'sd5);
        send_op(KIND_INS_BACK, MIN_VALUE);
        send_op(KIND_DEL_BACK, '0);
    endtask

    // Capacity lowered under the fill level: entries stay, inserts are refused.
    task automatic test_capacity_below_count();
        write_capacity(CNT_W'(4));
        send_op(KIND_INS_FRONT, 32'sd11);
        send_op(KIND_INS_BACK, 32'sd22);
        send_op(KIND_INS_FRONT, 32'sd33);
        write_capacity(CNT_W'(1));
        send_op(KIND_INS_BACK, 32'sd44);
        send_op(KIND_DEL_BACK, '0);
        send_op(KIND_DEL_FRONT, '0);
        send_op(KIND_INS_FRONT, 32'sd55);
        send_op(KIND_DEL_FRONT, '0);
    endtask

    // Random traffic over a series of capacities under one idling pattern.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int               done;
        int               n;
        logic [CNT_W-1:0] cap;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(11))
                0: cap = '0;
                1: cap = CAPACITY_TOP;
                2: cap = CNT_W'(DEPTH);
                3: cap = CNT_W'(1);
                4: cap = CNT_W'(2);
                5, 6: cap = CNT_W'($urandom_range(3, 8));
                7: cap = CNT_W'($urandom_range(0, 2047));
                default: cap = CNT_W'($urandom_range(1, 40));
            endcase
            write_capacity(cap);
            n = $urandom_range(25, 60);
            random_operations(n);
            done += n;
        end
    endtask

    // Capacity beyond the ring: a run of inserts, then one delete more than were inserted.
    task automatic test_capacity_beyond_depth();
        write_capacity(CAPACITY_TOP);
        repeat (38) begin
            send_op($urandom_range(1) ? KIND_INS_FRONT : KIND_INS_BACK, random_value());
        end
        send_op(KIND_INS_FRONT, MAX_VALUE);
        send_op(KIND_INS_BACK, MIN_VALUE);
        repeat (41) begin
            send_op($urandom_range(1) ? KIND_DEL_FRONT : KIND_DEL_BACK, random_value());
        end
    endtask

    // The receiver holds off for a long stretch so that the input side stalls.
    task automatic test_backpressure();
        write_capacity(CNT_W'(16));
        hold_off_cycles = 300;
        random_operations(48);
        wait_idle();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        fail_count      = 0;
        exp_wr_cnt      = 0;
        exp_rd_cnt      = 0;
        hold_off_cycles = 0;
        send_idle_pct   = 7;
        recv_idle_pct   = 64;
        mirror_head     = 0;
        mirror_count    = 0;
        mirror_capacity = CAPACITY_RESET;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_capacity_readback();
        test_empty_and_extremes();
        test_zero_capacity();
        test_capacity_below_count();
        test_random_traffic(7, 64, 130);
        test_random_traffic(64, 7, 130);
        test_random_traffic(0, 0, 90);
        test_capacity_beyond_depth();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_bounded_double_ended_queue_core passed");
        end else begin
            $display("tb_bounded_double_ended_queue_core failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("tb_bounded_double_ended_queue_core failed");
        $finish;
    end

endmodule
